// ===== design/ilid_pkg.sv =====
// Shared types and codes for the indexed list insert/delete block.
// Used by ilid_ctrl, ilid_dp and indexed_list_insert_delete; depends on nothing.
package ilid_pkg;

    // Default sizes of the list store.
    localparam int DEFAULT_LIST_DEPTH  = 64;
    localparam int DEFAULT_ENTRY_WIDTH = 32;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Status codes carried by a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;   // capture the input item
        logic check;      // capture the range and full check
        logic rd_first;   // read the first word the operation needs
        logic rd_next;    // read the next source word of a shift
        logic idx_init;   // load the shift write index
        logic shift;      // write the read word at the index and step it
        logic wr_new;     // write the inserted word at its position
        logic len_inc;    // one more entry held
        logic len_dec;    // one fewer entry held
        logic out_load;   // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_ins;      // held item is an insert
        logic op_del;      // held item is a delete
        logic op_rd;       // held item is a read
        logic ok;          // check passed
        logic at_tail;     // operation touches only the last slot
        logic shift_last;  // current shift step is the final one
        logic out_busy;    // result register holds an item not yet taken
    } sts_t;

endpackage

// ===== design/ilid_ctrl.sv =====
// Controller state machine for the indexed list insert/delete block.
// Depends on ilid_pkg for the command and status structs.
module ilid_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ilid_pkg::sts_t sts,
    output ilid_pkg::cmd_t cmd
);
    import ilid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_WR_NEW,
        S_DEC,
        S_RD_WAIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // One item at a time: new items only enter from idle.
    assign in_ready = (state_reg == S_IDLE);

    // Next state and the commands of the current state.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.ok && sts.op_ins)
                begin
                    if (sts.at_tail)
                    begin
                        state_next = S_WR_NEW;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        cmd.idx_init = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
                else if (sts.ok && sts.op_del)
                begin
                    if (sts.at_tail)
                    begin
                        state_next = S_DEC;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        cmd.idx_init = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
                else if (sts.ok && sts.op_rd)
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_RD_WAIT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_last)
                begin
                    state_next = sts.op_ins ? S_WR_NEW : S_DEC;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_WR_NEW:
            begin
                cmd.wr_new  = 1'b1;
                cmd.len_inc = 1'b1;
                state_next  = S_RESULT;
            end
            S_DEC:
            begin
                cmd.len_dec = 1'b1;
                state_next  = S_RESULT;
            end
            S_RD_WAIT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is loaded only into a free result register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over an item not yet taken");

    // Every accepted item is checked in the following cycle.
    a_check_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted item not checked next cycle");

    // Shifting never starts on an item that failed its check.
    a_shift_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_init |-> sts.ok)
        else $error("shift started on a failed check");

endmodule

// ===== design/ilid_dp.sv =====
// Datapath of the indexed list insert/delete block: entry memory, length,
// shift index and result register. Depends on ilid_pkg.
module ilid_dp #(
    parameter int LIST_DEPTH  = ilid_pkg::DEFAULT_LIST_DEPTH,
    parameter int ENTRY_WIDTH = ilid_pkg::DEFAULT_ENTRY_WIDTH,
    parameter int CNT_W       = $clog2(LIST_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             opcode,
    input  logic [CNT_W-1:0]       position,
    input  logic [ENTRY_WIDTH-1:0] entry_value,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [1:0]             status,
    output logic [ENTRY_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]       entry_count,
    input  ilid_pkg::cmd_t         cmd,
    output ilid_pkg::sts_t         sts
);
    import ilid_pkg::*;

    localparam int ADDR_W = $clog2(LIST_DEPTH);

    // Entry memory, one write and one registered read per cycle.
    logic [ENTRY_WIDTH-1:0] mem [LIST_DEPTH];
    logic [ENTRY_WIDTH-1:0] rdata_reg;

    logic [1:0]             op_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [ENTRY_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]       len_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [1:0]             res_st_reg;

    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [ENTRY_WIDTH-1:0] read_value_reg;
    logic [CNT_W-1:0]       entry_count_reg;

    logic [CNT_W:0]         pos_x;
    logic [CNT_W:0]         len_x;
    logic [CNT_W:0]         idx_x;
    logic [CNT_W:0]         rd_addr_x;
    logic [1:0]             chk_status;
    logic                   is_ins;
    logic                   is_del;
    logic                   is_rd;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic                   rd_en;

    assign pos_x  = {1'b0, pos_reg};
    assign len_x  = {1'b0, len_reg};
    assign idx_x  = {1'b0, idx_reg};
    assign is_ins = (op_reg == OP_INSERT);
    assign is_del = (op_reg == OP_DELETE);
    assign is_rd  = (op_reg == OP_READ);

    // Range check comes before the full check for an insert.
    always_comb
    begin
        chk_status = ST_OK;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (pos_reg > len_reg)
                begin
                    chk_status = ST_RANGE;
                end
                else if (len_reg == CNT_W'(LIST_DEPTH))
                begin
                    chk_status = ST_FULL;
                end
            end
            OP_DELETE, OP_READ:
            begin
                if (pos_reg >= len_reg)
                begin
                    chk_status = ST_RANGE;
                end
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        sts.op_ins     = is_ins;
        sts.op_del     = is_del;
        sts.op_rd      = is_rd;
        sts.ok         = (chk_status == ST_OK);
        sts.at_tail    = is_ins ? (pos_x == len_x) : (pos_x + 1'b1 == len_x);
        sts.shift_last = is_ins ? (idx_x == pos_x + 1'b1) : (idx_x + 2'd2 == len_x);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    // Read address: first source word, then one step further each shift.
    always_comb
    begin
        if (cmd.rd_first)
        begin
            if (is_ins)
            begin
                rd_addr_x = len_x - 1'b1;
            end
            else if (is_del)
            begin
                rd_addr_x = pos_x + 1'b1;
            end
            else
            begin
                rd_addr_x = pos_x;
            end
        end
        else
        begin
            rd_addr_x = is_ins ? (idx_x - 2'd2) : (idx_x + 2'd2);
        end
    end

    assign rd_en   = cmd.rd_first || cmd.rd_next;
    assign wr_en   = cmd.shift || cmd.wr_new;
    assign wr_addr = cmd.wr_new ? pos_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_data = cmd.wr_new ? val_reg : rdata_reg;

    // Entry memory access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr_x[ADDR_W-1:0]];
        end
    end

    // Held item, check result and shift index.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= entry_value;
        end
        if (cmd.check)
        begin
            res_st_reg <= chk_status;
        end
        if (cmd.idx_init)
        begin
            idx_reg <= is_ins ? len_reg : pos_reg;
        end
        else if (cmd.shift)
        begin
            idx_reg <= is_ins ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cmd.len_inc)
        begin
            len_reg <= len_reg + 1'b1;
        end
        else if (cmd.len_dec)
        begin
            len_reg <= len_reg - 1'b1;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; the read word shows only for a successful read.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg      <= res_st_reg;
            read_value_reg  <= (is_rd && res_st_reg == ST_OK) ? rdata_reg : '0;
            entry_count_reg <= len_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

    // The count never passes the capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond capacity");

    // An insert grows the list by exactly one entry.
    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.len_inc |=> (len_reg == $past(len_reg) + 1'b1))
        else $error("entry count did not grow by one");

    // A shift write stays at or below the length and, for an insert, off its own position.
    a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> (idx_reg <= len_reg) && (idx_reg != pos_reg || is_del))
        else $error("shift write outside the list");

    // Never two writers on the memory in one cycle.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift && cmd.wr_new))
        else $error("two memory writes in one cycle");

endmodule

// ===== design/indexed_list_insert_delete.sv =====
// Indexed list insert/delete block: an ordered list store of fixed depth.
// Top level; instantiates ilid_ctrl and ilid_dp, depends on ilid_pkg.
//
// Usage: each input item (opcode, position, entry_value) on the in_valid /
// in_ready channel inserts a word at a position, deletes the entry at a
// position, or reads it. Each item gives exactly one result item (status,
// read_value, entry_count) on the out_valid / out_ready channel.
// An item is checked first. An insert or delete then moves the entries behind
// its position one word at a time and writes the new word or counts down, a
// read waits for its memory word, and a rejected item goes straight on; each
// then lands in the result register. The next item is accepted only after the
// result is loaded. An insert or delete moves at most LIST_DEPTH - 1 entries;
// the single write port of the entry memory moves one word a cycle.
// Reset empties the list at once; memory words hold no value until written.
// When the receiver stalls, the result register holds its item; the next
// item may still be accepted and worked, and waits for the register to free.
module indexed_list_insert_delete #(
    parameter int LIST_DEPTH  = ilid_pkg::DEFAULT_LIST_DEPTH,
    parameter int ENTRY_WIDTH = ilid_pkg::DEFAULT_ENTRY_WIDTH,
    parameter int CNT_W       = $clog2(LIST_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [CNT_W-1:0]       position,
    input  logic [ENTRY_WIDTH-1:0] entry_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [ENTRY_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]       entry_count
);
    import ilid_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing of each operation.
    ilid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage, checks and the result register.
    ilid_dp #(
        .LIST_DEPTH  (LIST_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (opcode),
        .position    (position),
        .entry_value (entry_value),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== test/indexed_list_insert_delete_tb.sv =====
// Testbench for indexed_list_insert_delete: drives list operations and checks every result
// against a behavioral list model kept inside this file.
// Depends on ilid_pkg and the indexed_list_insert_delete RTL.
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;
    import ilid_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_LIST_DEPTH;
    localparam int ENTRY_WIDTH = DEFAULT_ENTRY_WIDTH;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int POS_MAX     = (1 << CNT_W) - 1;

    // The one opcode the block defines as doing nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result item as the block should present it.
    typedef struct packed {
        logic [1:0]             status;
        logic [ENTRY_WIDTH-1:0] read_value;
        logic [CNT_W-1:0]       entry_count;
    } list_result_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [1:0]             opcode      = OP_READ;
    logic [CNT_W-1:0]       position    = '0;
    logic [ENTRY_WIDTH-1:0] entry_value = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [1:0]             status;
    logic [ENTRY_WIDTH-1:0] read_value;
    logic [CNT_W-1:0]       entry_count;

    // Model of the list contents and length, updated as each item is accepted.
    logic [ENTRY_WIDTH-1:0] model_entries [LIST_DEPTH];
    int                     model_length = 0;
    list_result_t           awaited_results [$];

    int error_count       = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    indexed_list_insert_delete #(
        .LIST_DEPTH  (LIST_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .position    (position),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always #5 clk = ~clk;

    // Apply one operation to the list model and return the result it should give.
    function automatic list_result_t apply_list_op(logic [1:0] op, int pos,
                                                   logic [ENTRY_WIDTH-1:0] val);
        list_result_t res;
        res.status     = ST_OK;
        res.read_value = '0;
        case (op)
            OP_INSERT:
            begin
                if (pos > model_length)
                    res.status = ST_RANGE;
                else if (model_length >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = model_length; i > pos; i--)
                        model_entries[i] = model_entries[i-1];
                    model_entries[pos] = val;
                    model_length++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= model_length)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < model_length; i++)
                        model_entries[i] = model_entries[i+1];
                    model_entries[model_length-1] = '0;
                    model_length--;
                end
            end
            OP_READ:
            begin
                if (pos >= model_length)
                    res.status = ST_RANGE;
                else
                    res.read_value = model_entries[pos];
            end
            default:
            begin
                // The unused opcode leaves everything as it is.
            end
        endcase
        res.entry_count = CNT_W'(model_length);
        return res;
    endfunction

    task automatic report_failure(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Send one item, honoring the sender idle rate, and record its expected result.
    task automatic send_list_op(logic [1:0] op, logic [CNT_W-1:0] pos,
                                logic [ENTRY_WIDTH-1:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        position    <= pos;
        entry_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_results.push_back(apply_list_op(op, int'(pos), val));
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ENTRY_WIDTH-1:0] pick_entry_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, with boundary and out-of-range ones mixed in.
    function automatic logic [CNT_W-1:0] pick_position(logic [1:0] op);
        int top;
        top = (op == OP_INSERT) ? model_length : model_length - 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
            begin
                if (top < 0)
                    return CNT_W'(model_length);
                return CNT_W'($urandom_range(0, top));
            end
            7: return CNT_W'(model_length);
            8: return CNT_W'($urandom_range(model_length, POS_MAX));
            default: return CNT_W'($urandom_range(0, POS_MAX));
        endcase
    endfunction

    // Send one random operation; weights are percentages, the rest goes to the unused opcode.
    task automatic send_random_op(int ins_w, int del_w, int rd_w);
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < ins_w)
            op = OP_INSERT;
        else if (pick < ins_w + del_w)
            op = OP_DELETE;
        else if (pick < ins_w + del_w + rd_w)
            op = OP_READ;
        else
            op = OP_UNUSED;
        send_list_op(op, pick_position(op), pick_entry_value());
    endtask

    // Every operation on an empty list is out of range, except the unused opcode.
    task automatic test_empty_list_errors();
        send_list_op(OP_READ, 0, '0);
        send_list_op(OP_DELETE, 0, '0);
        send_list_op(OP_INSERT, 1, 32'h0BAD_F00D);
        send_list_op(OP_UNUSED, CNT_W'(POS_MAX), '1);
        send_list_op(OP_READ, CNT_W'(POS_MAX), '1);
    endtask

    // Insert and delete at head, middle and tail, reading back the order after the inserts and some deletes.
    task automatic test_shift_on_insert_and_delete();
        send_list_op(OP_INSERT, 0, '1);
        send_list_op(OP_INSERT, 0, '0);
        send_list_op(OP_INSERT, 2, 32'h1234_5678);
        send_list_op(OP_INSERT, 1, 32'hA5A5_A5A5);
        send_list_op(OP_INSERT, 5, 32'h5A5A_5A5A);
        for (int i = 0; i <= 4; i++)
            send_list_op(OP_READ, CNT_W'(i), '0);
        send_list_op(OP_DELETE, 1, '1);
        send_list_op(OP_READ, 1, '0);
        send_list_op(OP_DELETE, 2, '0);
        send_list_op(OP_DELETE, 0, '0);
        send_list_op(OP_READ, 0, '0);
        send_list_op(OP_UNUSED, 0, 32'hFFFF_0000);
        send_list_op(OP_DELETE, 1, '0);
        send_list_op(OP_INSERT, CNT_W'(POS_MAX), '1);
    endtask

    // Grow the list to capacity, then check that a full list refuses inserts and
    // that an out-of-range insert reports the range error ahead of the full one.
    task automatic test_fill_and_overflow();
        int guard;
        guard = 0;
        while (model_length < LIST_DEPTH && guard < 500)
        begin
            send_random_op(80, 8, 8);
            guard++;
        end
        for (int i = 0; i < 3; i++)
            send_list_op(OP_INSERT, CNT_W'($urandom_range(0, LIST_DEPTH)),
                         pick_entry_value());
        send_list_op(OP_INSERT, CNT_W'($urandom_range(LIST_DEPTH + 1, POS_MAX)),
                     pick_entry_value());
        send_list_op(OP_READ, CNT_W'(LIST_DEPTH - 1), '0);
        send_list_op(OP_READ, CNT_W'(LIST_DEPTH), '0);
    endtask

    // Shrink the list back to empty, then try the operations that must fail on it.
    task automatic test_drain_to_empty();
        int guard;
        guard = 0;
        while (model_length > 0 && guard < 500)
        begin
            send_random_op(8, 80, 8);
            guard++;
        end
        send_list_op(OP_DELETE, 0, '0);
        send_list_op(OP_READ, 0, '0);
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++)
            send_random_op(35, 30, 27);
    endtask

    // Receiver stalls at random at the rate of the current phase.
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
                report_failure($sformatf("result with nothing expected: status %0d", status));
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    report_failure($sformatf("status %0d, expected %0d",
                                             status, want.status));
                if (read_value !== want.read_value)
                    report_failure($sformatf("read_value %08h, expected %08h",
                                             read_value, want.read_value));
                if (entry_count !== want.entry_count)
                    report_failure($sformatf("entry_count %0d, expected %0d",
                                             entry_count, want.entry_count));
            end
        end
    end

    // Main sequence: reset, directed checks, then three idling phases of random traffic.
    initial
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
            model_entries[i] = '0;
        sender_idle_pct   = 17;
        receiver_idle_pct = 53;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list_errors();
        wait_results_drained();
        test_shift_on_insert_and_delete();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 17;
                    receiver_idle_pct = 53;
                end
                1:
                begin
                    sender_idle_pct   = 53;
                    receiver_idle_pct = 17;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            test_fill_and_overflow();
            test_random_mix(55);
            test_drain_to_empty();
            test_random_mix(55);
            wait_results_drained();
        end

        repeat (LIST_DEPTH + 8) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
